// ----- sv/mfadd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfadd_pkg
// Format codes and conversion helpers for the multi-format float adder.
// ----------------------------------------------------------------------------
package mfadd_pkg;

  localparam logic [1:0] FMT_BF16   = 2'd0;
  localparam logic [1:0] FMT_HALF   = 2'd1;
  localparam logic [1:0] FMT_SINGLE = 2'd2;

  localparam logic [31:0] QNAN32   = 32'h7fc0_0000;
  localparam logic [15:0] BF16_QB  = 16'h0040;
  localparam logic [31:0] BF16_RND = 32'h0000_7fff;

  // Leading zeros of a 27-bit value; 27 when zero.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    cnt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) cnt = 5'(26 - i);
    end
    return cnt;
  endfunction

  // Exact widening of a half-precision value to single precision.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] k;
    logic [10:0] mn;
    logic [7:0] ex;
    s  = h[15];
    e  = h[14:10];
    m  = h[9:0];
    k  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) k = 4'(10 - i);
    end
    mn = {1'b0, m} << k;
    ex = 8'd113 - {4'd0, k};
    if (e == 5'h1f) begin
      return {s, 8'hff, m, 13'd0};
    end else if (e == 5'd0) begin
      if (m == 10'd0) return {s, 31'd0};
      return {s, ex, mn[9:0], 13'd0};
    end
    return {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
  endfunction

  // Round a single-precision value to half precision, nearest even.
  function automatic logic [31:0] single_to_half(input logic [31:0] u);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    logic [25:0] full;
    logic [4:0]  sh;
    logic [14:0] base;
    logic [25:0] q;
    logic [25:0] rem;
    logic [25:0] halfv;
    logic        up;
    logic [15:0] h;
    s = u[31];
    e = u[30:23];
    m = u[22:0];
    full = {2'b00, 1'b1, m};
    if (e >= 8'd113) begin
      sh   = 5'd13;
      base = 15'({e - 8'd113, 10'd0});
    end else begin
      sh   = (e < 8'd101) ? 5'd25 : 5'(8'd126 - e);
      base = 15'd0;
    end
    q     = full >> sh;
    rem   = full & ((26'd1 << sh) - 26'd1);
    halfv = 26'd1 << (sh - 5'd1);
    up    = (rem > halfv) || ((rem == halfv) && q[0]);
    h     = {1'b0, base} + 16'(q) + {15'd0, up};
    if (h >= 16'h7c00) h = 16'h7c00;
    if (e == 8'hff) begin
      if (m == 23'd0) return {16'd0, s, 15'h7c00};
      return {16'd0, s, 6'h3f, m[21:13]};
    end else if (e == 8'd0) begin
      return {16'd0, s, 15'd0};
    end else if (e >= 8'd143) begin
      return {16'd0, s, 15'h7c00};
    end
    return {16'd0, s, h[14:0]};
  endfunction

  // Round a single-precision value to bfloat16.
  function automatic logic [31:0] bf16_round(input logic [31:0] u);
    logic [31:0] t;
    t = u + BF16_RND + {31'd0, u[16]};
    if (u[30:23] == 8'hff && u[22:0] != 23'd0) return {16'd0, u[31:16] | BF16_QB};
    return {16'd0, t[31:16]};
  endfunction

endpackage

// ----- sv/multi_format_float_adder.sv -----
// ----------------------------------------------------------------------------
// multi_format_float_adder
// Pipelined float adder for bfloat16, half and single precision operands.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_ready in_left_bits in_right_bits | request in
//  out     | out_valid out_ready out_sum_bits       | request out
//  cfg     | cfg_wr_en cfg_wr_data                  | register write
//
// One request per cycle unless stalled; it passes stages 0 to 5 before out_valid.
// The whole pipe advances together: it stalls only when the output register
// holds a request that out_ready does not take.
// rst_n (synchronous) clears every stage valid bit and sets the format to bfloat16.
// Each request carries the format it was accepted with down the pipe.
module multi_format_float_adder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_left_bits,
  input  logic [31:0] in_right_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sum_bits
);
  import mfadd_pkg::*;

  logic [1:0] fmt_reg_r;
  logic       adv;
  logic [5:0] vld_r;

  // Stage 0: widened operands
  logic [31:0] a0_r, b0_r, a0_nxt, b0_nxt;
  logic [1:0]  f0_r;
  // Stage 1: unpacked, ordered operands
  logic        sgn1_r, sub1_r, zs1_r, spc1_r;
  logic [7:0]  e1_r;
  logic [23:0] mb1_r, ms1_r;
  logic [4:0]  d1_r;
  logic [31:0] sv1_r;
  logic [1:0]  f1_r;
  // Stage 2: raw sum
  logic        sgn2_r, zs2_r, spc2_r;
  logic [7:0]  e2_r;
  logic [27:0] sum2_r;
  logic [31:0] sv2_r;
  logic [1:0]  f2_r;
  // Stage 3: normalized
  logic        sgn3_r, zs3_r, spc3_r, zero3_r;
  logic [8:0]  e3_r;
  logic [26:0] m3_r;
  logic [31:0] sv3_r;
  logic [1:0]  f3_r;
  // Stage 4: single-precision result
  logic [31:0] r4_r;
  logic [1:0]  f4_r;
  // Stage 5: output register
  logic [31:0] out_r;

  assign adv       = !vld_r[5] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[5];
  assign out_sum_bits = out_r;

  // Format register; the user must write it only while the pipe is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_reg_r <= FMT_BF16;
    end else if (cfg_wr_en) begin
      fmt_reg_r <= cfg_wr_data;
    end
  end

  // Advance the valid bits together with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // Widen the 16-bit formats to single precision.
  always_comb begin
    case (fmt_reg_r)
      FMT_BF16: begin
        a0_nxt = {in_left_bits[15:0], 16'd0};
        b0_nxt = {in_right_bits[15:0], 16'd0};
      end
      FMT_HALF: begin
        a0_nxt = half_to_single(in_left_bits[15:0]);
        b0_nxt = half_to_single(in_right_bits[15:0]);
      end
      default: begin
        a0_nxt = in_left_bits;
        b0_nxt = in_right_bits;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r <= a0_nxt;
      b0_r <= b0_nxt;
      f0_r <= fmt_reg_r;
    end
  end

  // Unpack, order by magnitude, detect NaN and infinity cases.
  logic        a_nan, b_nan, a_inf, b_inf, swap_nxt;
  logic [31:0] big_nxt, sml_nxt, sv1_nxt;
  logic        spc1_nxt;
  logic [7:0]  eb_nxt, es_nxt, dd_nxt;

  always_comb begin
    a_nan    = (a0_r[30:23] == 8'hff) && (a0_r[22:0] != 23'd0);
    b_nan    = (b0_r[30:23] == 8'hff) && (b0_r[22:0] != 23'd0);
    a_inf    = (a0_r[30:0] == 31'h7f80_0000);
    b_inf    = (b0_r[30:0] == 31'h7f80_0000);
    swap_nxt = b0_r[30:0] > a0_r[30:0];
    big_nxt  = swap_nxt ? b0_r : a0_r;
    sml_nxt  = swap_nxt ? a0_r : b0_r;
    eb_nxt   = (big_nxt[30:23] == 8'd0) ? 8'd1 : big_nxt[30:23];
    es_nxt   = (sml_nxt[30:23] == 8'd0) ? 8'd1 : sml_nxt[30:23];
    dd_nxt   = eb_nxt - es_nxt;
    spc1_nxt = 1'b1;
    if (a_nan)                               sv1_nxt = a0_r | 32'h0040_0000;
    else if (b_nan)                          sv1_nxt = b0_r | 32'h0040_0000;
    else if (a_inf && b_inf && a0_r != b0_r) sv1_nxt = QNAN32;
    else if (a_inf)                          sv1_nxt = a0_r;
    else if (b_inf)                          sv1_nxt = b0_r;
    else begin
      sv1_nxt  = a0_r;
      spc1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sgn1_r <= big_nxt[31];
      sub1_r <= a0_r[31] ^ b0_r[31];
      zs1_r  <= a0_r[31] & b0_r[31];
      spc1_r <= spc1_nxt;
      sv1_r  <= sv1_nxt;
      e1_r   <= eb_nxt;
      mb1_r  <= {big_nxt[30:23] != 8'd0, big_nxt[22:0]};
      ms1_r  <= {sml_nxt[30:23] != 8'd0, sml_nxt[22:0]};
      d1_r   <= (dd_nxt > 8'd27) ? 5'd27 : dd_nxt[4:0];
      f1_r   <= f0_r;
    end
  end

  // Align the smaller operand with a sticky bit, then add or subtract.
  logic [53:0] ext_nxt;
  logic [26:0] al_nxt;
  logic [27:0] sum_nxt;

  always_comb begin
    ext_nxt = {ms1_r, 3'd0, 27'd0} >> d1_r;
    al_nxt  = {ext_nxt[53:28], ext_nxt[27] | (|ext_nxt[26:0])};
    if (sub1_r) sum_nxt = {1'b0, mb1_r, 3'd0} - {1'b0, al_nxt};
    else        sum_nxt = {1'b0, mb1_r, 3'd0} + {1'b0, al_nxt};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sgn2_r <= sgn1_r;
      zs2_r  <= zs1_r;
      spc2_r <= spc1_r;
      sv2_r  <= sv1_r;
      e2_r   <= e1_r;
      sum2_r <= sum_nxt;
      f2_r   <= f1_r;
    end
  end

  // Normalize: one right shift on carry, else a left shift bounded by the
  // exponent so that small results stay denormal.
  logic [4:0]  lz_nxt, sh_nxt;
  logic [7:0]  lim_nxt;
  logic [26:0] m3_nxt;
  logic [8:0]  e3_nxt;

  always_comb begin
    lz_nxt  = lzc27(sum2_r[26:0]);
    lim_nxt = e2_r - 8'd1;
    sh_nxt  = ({3'd0, lz_nxt} > lim_nxt) ? lim_nxt[4:0] : lz_nxt;
    if (sum2_r[27]) begin
      m3_nxt = {sum2_r[27:2], sum2_r[1] | sum2_r[0]};
      e3_nxt = {1'b0, e2_r} + 9'd1;
    end else begin
      m3_nxt = sum2_r[26:0] << sh_nxt;
      e3_nxt = m3_nxt[26] ? ({1'b0, e2_r} - {4'd0, sh_nxt}) : 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sgn3_r  <= sgn2_r;
      zs3_r   <= zs2_r;
      spc3_r  <= spc2_r;
      sv3_r   <= sv2_r;
      zero3_r <= (sum2_r == 28'd0);
      m3_r    <= m3_nxt;
      e3_r    <= e3_nxt;
      f3_r    <= f2_r;
    end
  end

  // Round to nearest even; the carry out of the mantissa bumps the exponent.
  logic        up_nxt;
  logic [30:0] pk_nxt;
  logic [31:0] r4_nxt;

  always_comb begin
    up_nxt = m3_r[2] & (m3_r[3] | m3_r[1] | m3_r[0]);
    pk_nxt = {e3_r[7:0], m3_r[25:3]} + {30'd0, up_nxt};
    if (spc3_r)                  r4_nxt = sv3_r;
    else if (zero3_r)            r4_nxt = {zs3_r, 31'd0};
    else if (e3_r >= 9'd255)     r4_nxt = {sgn3_r, 31'h7f80_0000};
    else                         r4_nxt = {sgn3_r, pk_nxt};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_r <= r4_nxt;
      f4_r <= f3_r;
    end
  end

  // Narrow to the request's format.
  logic [31:0] out_nxt;

  always_comb begin
    case (f4_r)
      FMT_BF16: out_nxt = bf16_round(r4_r);
      FMT_HALF: out_nxt = single_to_half(r4_r);
      default:  out_nxt = r4_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- sv/mfadd_checker.sv -----
// ----------------------------------------------------------------------------
// mfadd_checker
// Port-level checks for the multi-format float adder.
// ----------------------------------------------------------------------------
module mfadd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [1:0]  cfg_wr_data,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sum_bits
);
  import mfadd_pkg::*;

  logic [1:0] fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_BF16;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_bits))
    else $error("result dropped or changed under stall");

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (fmt_r == FMT_BF16 || fmt_r == FMT_HALF) |-> out_sum_bits[31:16] == 16'd0)
    else $error("upper half set for 16-bit format");

endmodule

bind multi_format_float_adder mfadd_checker u_mfadd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .cfg_wr_en    (cfg_wr_en),
  .cfg_wr_data  (cfg_wr_data),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_sum_bits (out_sum_bits)
);

// ----- tb/multi_format_float_adder_tb.sv -----
// ----------------------------------------------------------------------------
// multi_format_float_adder_tb
// Self-checking bench for the multi-format float adder. A directed table walks
// the extremes and special cases of each format, then random operand pairs run
// under three idling schemes, checked against typed sums or a bit-exact model.
// ----------------------------------------------------------------------------
module multi_format_float_adder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfadd_pkg::*;

  // Spare selector value; the block treats it as single precision.
  localparam logic [1:0] FMT_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;   // more than the pipe's depth
  localparam int STALL_LIMIT   = 4000; // cycles with no request moving
  localparam int RAND_PER_MODE = 420;
  localparam int FMT_SEGMENT   = 105;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_left_bits = '0;
  logic [31:0] in_right_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_sum_bits;

  multi_format_float_adder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_bits (in_left_bits),
    .in_right_bits(in_right_bits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sum_bits (out_sum_bits)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the format register and the queue of sums still owed.
  logic [1:0]  fmt_shadow = FMT_BF16;
  logic [31:0] pending_sums[$];
  int          mismatches = 0;
  int          sums_checked = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          stall_cycles = 0;

  // --------------------------------------------------------------------------
  // Bit-exact arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_nan(input logic [31:0] u);
    return u[30:23] == 8'hff && u[22:0] != 23'd0;
  endfunction

  // IEEE single add, round to nearest even, denormals kept.
  function automatic logic [31:0] fp32_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [27:0] mx, my, r;
    logic [24:0] mm;
    int          e, d;
    bit          up;
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if (a[30:0] == 31'h7f80_0000 && b[30:0] == 31'h7f80_0000 && a != b) return QNAN32;
    if (a[30:0] == 31'h7f80_0000) return a;
    if (b[30:0] == 31'h7f80_0000) return b;
    // put the larger magnitude first so the sign follows it
    if (b[30:0] > a[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    mx = {1'b0, a[30:23] != 8'd0, a[22:0], 3'b000};
    my = {1'b0, b[30:23] != 8'd0, b[22:0], 3'b000};
    e  = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    d  = e - ((b[30:23] == 8'd0) ? 1 : int'(b[30:23]));
    // align with a sticky bit for whatever falls off
    if (d >= 27) my = {27'd0, my != 28'd0};
    else if (d > 0) my = (my >> d) | 28'((my & ((28'd1 << d) - 28'd1)) != 28'd0);
    r = (a[31] == b[31]) ? mx + my : mx - my;
    if (r == 28'd0) return (a[31] & b[31]) ? 32'h8000_0000 : 32'd0;
    if (r[27]) begin
      r = (r >> 1) | {27'd0, r[0]};
      e++;
    end
    while (!r[26] && e > 1) begin
      r = r << 1;
      e--;
    end
    up = r[2] && (r[1:0] != 2'd0 || r[3]);
    mm = {1'b0, r[26:3]} + {24'd0, up};
    if (mm[24]) begin
      mm = mm >> 1;
      e++;
    end
    if (e >= 255) return {a[31], 8'hff, 23'd0};
    return {a[31], mm[23] ? 8'(e) : 8'd0, mm[22:0]};
  endfunction

  function automatic logic [15:0] round_to_bf16(input logic [31:0] u);
    logic [31:0] t;
    if (is_nan(u)) return u[31:16] | BF16_QB;
    t = u + BF16_RND + {31'd0, u[16]};
    return t[31:16];
  endfunction

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [10:0] m;
    logic [7:0]  ex;
    m  = {1'b0, h[9:0]};
    ex = 8'd113;
    if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
    if (h[14:10] == 5'd0) begin
      if (m == 11'd0) return {h[15], 31'd0};
      while (!m[10]) begin
        m = m << 1;
        ex--;
      end
      return {h[15], ex, m[9:0], 13'd0};
    end
    return {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] rne_shift(input logic [31:0] v, input int sh);
    logic [31:0] q, rem, halfway;
    q       = v >> sh;
    rem     = v & ((32'd1 << sh) - 32'd1);
    halfway = 32'd1 << (sh - 1);
    if (rem > halfway || (rem == halfway && q[0])) q++;
    return q;
  endfunction

  function automatic logic [15:0] narrow_half(input logic [31:0] u);
    logic [15:0] s;
    logic [31:0] full, h;
    int          ue;
    s    = {u[31], 15'd0};
    full = {8'd0, 1'b1, u[22:0]};
    if (u[30:23] == 8'hff) begin
      if (u[22:0] == 23'd0) return s | 16'h7c00;
      return s | 16'h7e00 | 16'(u[22:0] >> 13);
    end
    if (u[30:23] == 8'd0) return s;
    ue = int'(u[30:23]) - 127;
    if (ue >= 16) return s | 16'h7c00;
    if (ue >= -14) begin
      h = (32'(ue + 14) << 10) + rne_shift(full, 13);
      if (h >= 32'h7c00) h = 32'h7c00;
      return s | h[15:0];
    end
    if (-ue - 1 > 25) return s;
    h = rne_shift(full, -ue - 1);
    return s | h[15:0];
  endfunction

  function automatic logic [31:0] formatted_sum(input logic [1:0] fmt, input logic [31:0] a,
                                                input logic [31:0] b);
    case (fmt)
      FMT_BF16: begin
        return {16'd0, round_to_bf16(fp32_sum({a[15:0], 16'd0}, {b[15:0], 16'd0}))};
      end
      FMT_HALF: begin
        return {16'd0, narrow_half(fp32_sum(widen_half(a[15:0]), widen_half(b[15:0])))};
      end
      default: begin
        return fp32_sum(a, b);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table: sums typed in where they are obvious, else predicted
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] sum;
    bit          known;
  } add_case_t;

  localparam int N_CASES = 24;
  add_case_t add_cases [N_CASES] = '{
    '{FMT_BF16,   32'h0000_3f80, 32'h0000_3f80, 32'h0000_4000, 1'b1}, // 1 + 1
    '{FMT_BF16,   32'hdead_3f80, 32'hbeef_3f80, 32'h0000_4000, 1'b1}, // upper bits ignored
    '{FMT_BF16,   32'h0000_7f81, 32'h0000_3f80, 32'h0000_7fc1, 1'b1}, // left NaN quieted
    '{FMT_BF16,   32'h0000_3f80, 32'h0000_ff81, 32'h0000_ffc1, 1'b1}, // right NaN quieted
    '{FMT_BF16,   32'h0000_7f80, 32'h0000_ff80, 32'h0000_7fc0, 1'b1}, // inf - inf
    '{FMT_BF16,   32'h0000_7f7f, 32'h0000_7f7f, 32'h0000_7f80, 1'b1}, // overflow
    '{FMT_BF16,   32'h0000_0001, 32'h0000_0001, 32'h0,         1'b0}, // denormals
    '{FMT_BF16,   32'hffff_ffff, 32'hffff_ffff, 32'h0000_ffff, 1'b1}, // all ones NaN
    '{FMT_BF16,   32'h0000_3f81, 32'h0000_3380, 32'h0,         1'b0}, // rounding tie
    '{FMT_HALF,   32'h0000_3c00, 32'h0000_3c00, 32'h0000_4000, 1'b1},
    '{FMT_HALF,   32'h0000_7c01, 32'h0000_3c00, 32'h0,         1'b0}, // left NaN
    '{FMT_HALF,   32'h0000_3c00, 32'h0000_fe00, 32'h0,         1'b0}, // right NaN
    '{FMT_HALF,   32'h0000_7c00, 32'h0000_fc00, 32'h0000_7e00, 1'b1}, // inf - inf
    '{FMT_HALF,   32'hffff_7bff, 32'h0000_7bff, 32'h0000_7c00, 1'b1}, // overflow
    '{FMT_HALF,   32'h0000_0001, 32'h0000_8003, 32'h0,         1'b0}, // denormals
    '{FMT_HALF,   32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b1}, // -0 + -0
    '{FMT_SINGLE, 32'h3f80_0000, 32'h3f80_0000, 32'h4000_0000, 1'b1},
    '{FMT_SINGLE, 32'h7f7f_ffff, 32'h7f7f_ffff, 32'h7f80_0000, 1'b1}, // overflow
    '{FMT_SINGLE, 32'h7f80_0000, 32'hff80_0000, QNAN32,        1'b1}, // inf - inf
    '{FMT_SINGLE, 32'hff80_0001, 32'h3f80_0000, 32'hffc0_0001, 1'b1}, // left NaN
    '{FMT_SINGLE, 32'h4049_0fdb, 32'hc049_0fdb, 32'h0000_0000, 1'b1}, // exact cancel
    '{FMT_SINGLE, 32'h0000_0001, 32'h807f_ffff, 32'h0,         1'b0}, // denormals
    '{FMT_SPARE,  32'h3f80_0000, 32'h3f80_0000, 32'h4000_0000, 1'b1}, // spare selector
    '{FMT_SPARE,  32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b1}
  };

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Hold until every owed sum has come back, then let the pipe settle.
  task automatic drain();
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = fmt;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    fmt_shadow  = fmt;
  endtask

  // Offer one request and hold it until accepted; the predicted sum is queued
  // at the accepting edge.
  task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] sum, input bit known);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_left_bits  = a;
    in_right_bits = b;
    do @(posedge clk); while (!in_ready);
    pending_sums.push_back(known ? sum : formatted_sum(fmt_shadow, a, b));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Operand mix: raw noise, special encodings, small magnitudes, and values near
  // the other one so that cancellation and alignment edges are hit.
  function automatic logic [31:0] pick_operand(input logic [1:0] fmt, input logic [31:0] other);
    logic [31:0] raw;
    bit          narrow;
    raw    = $urandom;
    narrow = (fmt == FMT_BF16 || fmt == FMT_HALF);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: raw[15:0] = 16'h0000;
          1: raw[15:0] = (fmt == FMT_HALF) ? 16'h7c00 : 16'h7f80;
          2: raw[15:0] = (fmt == FMT_HALF) ? 16'h7bff : 16'h7f7f;
          3: raw[15:0] = 16'($urandom_range(3));
          default: raw[15:0] = raw[15:0];
        endcase
        if (!narrow) begin
          case ($urandom_range(4))
            0: raw[30:0] = 31'h0;
            1: raw[30:0] = 31'h7f80_0000;
            2: raw[30:0] = 31'h7f7f_ffff;
            3: raw[30:0] = 31'($urandom_range(7));
            default: raw[30:0] = raw[30:0];
          endcase
        end
      end
      1, 2, 3: begin
        // near the other operand, with opposite sign
        if (narrow) raw[15:0] = other[15:0] ^ {1'b1, 11'd0, 4'($urandom)};
        else raw = other ^ {1'b1, 26'd0, 5'($urandom)};
      end
      4, 5: begin
        // small denormal-range magnitudes
        if (narrow) raw[14:8] = 7'd0;
        else raw[30:25] = 6'd0;
      end
      default: raw = raw;
    endcase
    return raw;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random backpressure, drop a sum into the check at each handshake
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected sum %08h with nothing pending", out_sum_bits);
      end else begin
        want = pending_sums.pop_front();
        sums_checked++;
        if (out_sum_bits !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: sum_bits expected %08h got %08h", want, out_sum_bits);
        end
      end
    end
  end

  // Watchdog: give up once no request has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] a, b;
    int          segment;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass with light idling; the register starts at bfloat16.
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    foreach (add_cases[i]) begin
      if (add_cases[i].fmt != fmt_shadow) set_format(add_cases[i].fmt);
      send_request(add_cases[i].left, add_cases[i].right, add_cases[i].sum,
                   add_cases[i].known);
    end

    // Random pass under three idling schemes, stepping the format each segment.
    segment = 0;
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 71 : 0;
      rx_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 25 : 0;
      for (int k = 0; k < RAND_PER_MODE; k++) begin
        if (k % FMT_SEGMENT == 0) begin
          set_format(2'(segment % 4));
          segment++;
        end
        // hold off the sender once until the pipe is empty
        if (mode == 0 && k == RAND_PER_MODE / 2) drain();
        a = pick_operand(fmt_shadow, $urandom);
        b = pick_operand(fmt_shadow, a);
        send_request(a, b, 32'd0, 1'b0);
      end
    end

    drain();
    $display("Covered %0d sums over bfloat16, half, single and the spare selector,",
             sums_checked);
    $display("with specials, cancellation and idling on both channels.");
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
